/* src/npc_pkg.sv */
// Shared types, constants and elaboration-time tables for the NTT convolution block.
// Holds the modulus, Barrett constant, command and status codes and twiddle tables.
// Has no dependencies; the top level and the multiplier refer to it by scoped names.
package npc_pkg;

  localparam int VAL_W = 30;
  localparam int IDX_W = 12;
  localparam int LEN_W = 13;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int CFG_IW = 1;
  localparam int DEF_MAX_POINTS = 4096;
  localparam int MUL_LAT = 5;

  localparam logic [63:0] MOD64 = 64'd998244353;
  localparam logic [VAL_W-1:0] P = 30'd998244353;
  localparam logic [VAL_W:0] MU = 31'(((64'd1 << 60) / MOD64));
  localparam logic [VAL_W-1:0] ONE = 30'd1;

  localparam logic [CFG_IW-1:0] REG_FIRST_LEN = 1'd0;
  localparam logic [CFG_IW-1:0] REG_SECOND_LEN = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_FIRST  = 2'd0,
    MODE_WR_SECOND = 2'd1,
    MODE_COMPUTE   = 2'd2,
    MODE_READ      = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_CAP   = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  localparam int TAB_N = 24;
  localparam int TAB_IW = 5;
  typedef logic [TAB_N-1:0][VAL_W-1:0] tab_t;

  localparam int TAB_FWD = 0;
  localparam int TAB_INV = 1;
  localparam int TAB_NINV = 2;

  function automatic logic [VAL_W-1:0] pow_mod_c(input logic [63:0] base,
                                                 input logic [31:0] e);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd1;
    b = base % MOD64;
    for (int i = 0; i < 32; i++) begin
      if (e[i]) r = (r * b) % MOD64;
      b = (b * b) % MOD64;
    end
    return r[VAL_W-1:0];
  endfunction

  // Entry k belongs to a transform stage of length 2**k.
  function automatic tab_t build_tab(input int sel);
    tab_t t;
    logic [31:0] e;
    logic [63:0] base;
    for (int k = 0; k < TAB_N; k++) begin
      base = 64'd3;
      e = 32'((MOD64 - 64'd1) >> k);
      if (sel == TAB_INV) begin
        e = 32'(MOD64 - 64'd1 - ((MOD64 - 64'd1) >> k));
      end else if (sel == TAB_NINV) begin
        base = 64'd1 << k;
        e = 32'(MOD64 - 64'd2);
      end
      t[k] = pow_mod_c(base, e);
    end
    return t;
  endfunction

  localparam tab_t ROOT_FWD = build_tab(TAB_FWD);
  localparam tab_t ROOT_INV = build_tab(TAB_INV);
  localparam tab_t N_INV = build_tab(TAB_NINV);

  function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] x,
                                               input logic [VAL_W-1:0] y);
    logic [VAL_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, P}) s = s - {1'b0, P};
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] x,
                                               input logic [VAL_W-1:0] y);
    logic [VAL_W:0] d;
    if (x >= y) d = {1'b0, x} - {1'b0, y};
    else d = {1'b0, x} + {1'b0, P} - {1'b0, y};
    return d[VAL_W-1:0];
  endfunction

endpackage

/* src/ntt_polynomial_convolution.sv */
// Polynomial multiplier modulo 998244353 built on one shared modular multiplier.
// Depends on npc_pkg, npc_ram and npc_modmul.
//
// A compute command pads to n, the next power of two that holds the product, copies
// both operands into the work RAMs, transforms each, multiplies them pointwise,
// transforms back and applies the final scaling. Every butterfly runs on the single
// five-stage modular multiplier and the one read and one write port of each work
// RAM. No clearing pass follows reset. The block takes no new command while one is
// in progress.
module ntt_polynomial_convolution #(
  parameter int MAX_POINTS = npc_pkg::DEF_MAX_POINTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [npc_pkg::MODE_W-1:0] in_mode,
  input  logic [npc_pkg::IDX_W-1:0]  in_index,
  input  logic [npc_pkg::VAL_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [npc_pkg::VAL_W-1:0]  out_coefficient,
  output logic [npc_pkg::STAT_W-1:0] out_status,
  input  logic                       cfg_we,
  input  logic [npc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [npc_pkg::LEN_W-1:0]  cfg_data
);

  localparam int VW = npc_pkg::VAL_W;
  localparam int LW = npc_pkg::LEN_W;
  localparam int SAW = $clog2(MAX_POINTS);
  localparam int WAW = $clog2(2 * MAX_POINTS - 1);
  localparam int WDEPTH = 1 << WAW;
  localparam int CW = WAW + 1;
  localparam int LGW = $clog2(WAW + 1);
  localparam int TIW = npc_pkg::TAB_IW;
  localparam int PHW = 4;
  localparam logic [PHW-1:0] PH_RD0 = 4'd0;
  localparam logic [PHW-1:0] PH_RD1 = 4'd1;
  localparam logic [PHW-1:0] PH_CAPV = 4'd2;
  localparam logic [PHW-1:0] PH_OPND = 4'd3;
  localparam logic [PHW-1:0] PH_MULI = 4'd4;
  localparam logic [PHW-1:0] PH_PROD = PHW'(4 + npc_pkg::MUL_LAT);
  localparam logic [PHW-1:0] PH_LAST = PHW'(5 + npc_pkg::MUL_LAT);
  localparam logic [PHW-1:0] PH_PWR = PHW'(1 + npc_pkg::MUL_LAT);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_SIZE, S_COPY, S_FWD, S_PMUL, S_INV, S_SCALE
  } state_t;

  state_t state_r;
  logic [PHW-1:0] ph_r;
  logic out_valid_r;
  logic [VW-1:0] out_coef_r;
  logic [npc_pkg::STAT_W-1:0] out_status_r;
  logic res_valid_r;
  logic [WAW-1:0] res_len_r;
  logic [WAW-1:0] need_r;
  logic [LW-1:0] fl_r;
  logic [LW-1:0] sl_r;
  logic [LGW-1:0] lgn_r;
  logic [LGW-1:0] lg_r;
  logic sel_b_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] blk_r;
  logic [WAW-1:0] j_r;
  logic [VW-1:0] w_r;
  logic [VW-1:0] u_r;
  logic [VW-1:0] v_r;
  logic [VW-1:0] opa_r;
  logic [VW-1:0] sum_r;
  logic [VW-1:0] diff_r;

  npc_pkg::mode_t mode_w;
  logic in_acc;
  logic out_set;
  logic len_bad;
  logic idx_ok;
  logic [VW-1:0] val_red;
  logic [CW-1:0] n_w;
  logic [CW-1:0] len_w;
  logic [CW-1:0] half_w;
  logic [WAW-1:0] p0_w;
  logic [WAW-1:0] p1_w;
  logic [VW-1:0] step_w;
  logic [VW-1:0] bf_rdata;
  logic bf_we;
  logic [WAW-1:0] bf_waddr;
  logic [VW-1:0] bf_wdata;
  logic [VW-1:0] mul_a;
  logic [VW-1:0] mul_b;
  logic [VW-1:0] mul_y;
  logic fs_we;
  logic ss_we;
  logic [VW-1:0] rd_f;
  logic [VW-1:0] rd_s;
  logic wa_we;
  logic [WAW-1:0] wa_waddr;
  logic [VW-1:0] wa_wdata;
  logic [WAW-1:0] wa_raddr;
  logic [VW-1:0] rd_a;
  logic wb_we;
  logic [WAW-1:0] wb_waddr;
  logic [VW-1:0] wb_wdata;
  logic [WAW-1:0] wb_raddr;
  logic [VW-1:0] rd_b_w;
  logic [VW-1:0] copy_f;
  logic [VW-1:0] copy_s;
  logic [CW+LW:0] need_sum;

  assign mode_w = npc_pkg::mode_t'(in_mode);
  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign in_acc = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_status = out_status_r;

  assign len_bad = (fl_r == '0) || (sl_r == '0) ||
                   (32'(fl_r) > 32'(MAX_POINTS)) || (32'(sl_r) > 32'(MAX_POINTS));
  assign idx_ok = 32'(in_index) < 32'(MAX_POINTS);
  assign val_red = (in_value >= npc_pkg::P) ? in_value - npc_pkg::P : in_value;
  assign need_sum = (CW+LW+1)'(fl_r) + (CW+LW+1)'(sl_r) - (CW+LW+1)'(1);

  assign n_w = CW'(1) << lgn_r;
  assign len_w = CW'(1) << lg_r;
  assign half_w = len_w >> 1;
  assign p0_w = WAW'(blk_r + CW'(j_r));
  assign p1_w = WAW'(blk_r + CW'(j_r) + half_w);
  assign step_w = (state_r == S_FWD) ? npc_pkg::ROOT_FWD[TIW'(lg_r)]
                                     : npc_pkg::ROOT_INV[TIW'(lg_r)];
  assign bf_rdata = sel_b_r ? rd_b_w : rd_a;

  assign copy_f = (32'(cnt_r) < 32'(fl_r)) ? rd_f : '0;
  assign copy_s = (32'(cnt_r) < 32'(sl_r)) ? rd_s : '0;

  always_comb begin
    out_set = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_set = 1'b1;
          if ((mode_w == npc_pkg::MODE_COMPUTE) && !len_bad) out_set = 1'b0;
          if ((mode_w == npc_pkg::MODE_READ) && res_valid_r &&
              (32'(in_index) < 32'(res_len_r))) out_set = 1'b0;
        end
      end
      S_READ: begin
        out_set = 1'b1;
      end
      S_SCALE: begin
        out_set = (ph_r == PH_PWR) && !(cnt_r + CW'(1) < n_w);
      end
      S_SIZE, S_COPY, S_FWD, S_PMUL, S_INV: begin
      end
    endcase
  end

  always_comb begin
    bf_we = 1'b0;
    bf_waddr = p0_w;
    bf_wdata = sum_r;
    if (state_r == S_FWD) begin
      if (ph_r == PH_MULI) begin
        bf_we = 1'b1;
      end else if (ph_r == PH_PROD) begin
        bf_we = 1'b1;
        bf_waddr = p1_w;
        bf_wdata = mul_y;
      end
    end else if (state_r == S_INV) begin
      if (ph_r == PH_PROD) begin
        bf_we = 1'b1;
        bf_wdata = npc_pkg::add_mod(u_r, mul_y);
      end else if (ph_r == PH_LAST) begin
        bf_we = 1'b1;
        bf_waddr = p1_w;
        bf_wdata = diff_r;
      end
    end
  end

  always_comb begin
    mul_a = w_r;
    mul_b = step_w;
    if ((state_r == S_FWD || state_r == S_INV) && ph_r == PH_MULI) begin
      mul_a = opa_r;
      mul_b = w_r;
    end else if (state_r == S_PMUL) begin
      mul_a = rd_a;
      mul_b = rd_b_w;
    end else if (state_r == S_SCALE) begin
      mul_a = rd_a;
      mul_b = npc_pkg::N_INV[TIW'(lgn_r)];
    end
  end

  always_comb begin
    fs_we = in_acc && (mode_w == npc_pkg::MODE_WR_FIRST) && idx_ok;
    ss_we = in_acc && (mode_w == npc_pkg::MODE_WR_SECOND) && idx_ok;

    wa_raddr = cnt_r[WAW-1:0];
    wb_raddr = cnt_r[WAW-1:0];
    if (state_r == S_IDLE) begin
      wa_raddr = WAW'(in_index);
    end else if (state_r == S_FWD || state_r == S_INV) begin
      wa_raddr = (ph_r == PH_RD1) ? p1_w : p0_w;
      wb_raddr = (ph_r == PH_RD1) ? p1_w : p0_w;
    end

    wa_we = 1'b0;
    wa_waddr = cnt_r[WAW-1:0];
    wa_wdata = mul_y;
    wb_we = 1'b0;
    wb_waddr = cnt_r[WAW-1:0];
    wb_wdata = copy_s;
    unique case (state_r)
      S_COPY: begin
        wa_we = (ph_r == PH_RD1);
        wb_we = (ph_r == PH_RD1);
        wa_wdata = copy_f;
      end
      S_FWD: begin
        wa_we = bf_we && !sel_b_r;
        wb_we = bf_we && sel_b_r;
        wa_waddr = bf_waddr;
        wb_waddr = bf_waddr;
        wa_wdata = bf_wdata;
        wb_wdata = bf_wdata;
      end
      S_INV: begin
        wa_we = bf_we;
        wa_waddr = bf_waddr;
        wa_wdata = bf_wdata;
      end
      S_PMUL, S_SCALE: begin
        wa_we = (ph_r == PH_PWR);
      end
      S_IDLE, S_READ, S_SIZE: begin
      end
    endcase
  end

  npc_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS), .AW(SAW)) u_first (
    .clk(clk), .we(fs_we), .waddr(SAW'(in_index)), .wdata(val_red),
    .raddr(SAW'(cnt_r)), .rdata(rd_f)
  );

  npc_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS), .AW(SAW)) u_second (
    .clk(clk), .we(ss_we), .waddr(SAW'(in_index)), .wdata(val_red),
    .raddr(SAW'(cnt_r)), .rdata(rd_s)
  );

  npc_ram #(.WIDTH(VW), .DEPTH(WDEPTH), .AW(WAW)) u_work_a (
    .clk(clk), .we(wa_we), .waddr(wa_waddr), .wdata(wa_wdata),
    .raddr(wa_raddr), .rdata(rd_a)
  );

  npc_ram #(.WIDTH(VW), .DEPTH(WDEPTH), .AW(WAW)) u_work_b (
    .clk(clk), .we(wb_we), .waddr(wb_waddr), .wdata(wb_wdata),
    .raddr(wb_raddr), .rdata(rd_b_w)
  );

  npc_modmul u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .y(mul_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r <= '0;
      out_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      res_len_r <= '0;
      fl_r <= LW'(1);
      sl_r <= LW'(1);
      sel_b_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          npc_pkg::REG_FIRST_LEN: fl_r <= cfg_data;
          npc_pkg::REG_SECOND_LEN: sl_r <= cfg_data;
        endcase
      end
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            out_coef_r <= '0;
            unique case (mode_w)
              npc_pkg::MODE_WR_FIRST, npc_pkg::MODE_WR_SECOND: begin
                out_status_r <= idx_ok ? npc_pkg::ST_OK : npc_pkg::ST_RANGE;
              end
              npc_pkg::MODE_COMPUTE: begin
                if (len_bad) begin
                  out_status_r <= npc_pkg::ST_CAP;
                  res_valid_r <= 1'b0;
                end else begin
                  need_r <= WAW'(need_sum);
                  lgn_r <= '0;
                  state_r <= S_SIZE;
                end
              end
              npc_pkg::MODE_READ: begin
                if (!res_valid_r) begin
                  out_status_r <= npc_pkg::ST_NONE;
                end else if (32'(in_index) >= 32'(res_len_r)) begin
                  out_status_r <= npc_pkg::ST_RANGE;
                end else begin
                  state_r <= S_READ;
                end
              end
            endcase
          end
        end
        S_READ: begin
          out_coef_r <= rd_a;
          out_status_r <= npc_pkg::ST_OK;
          state_r <= S_IDLE;
        end
        S_SIZE: begin
          if (n_w < CW'(need_r)) begin
            lgn_r <= lgn_r + LGW'(1);
          end else begin
            cnt_r <= '0;
            ph_r <= '0;
            state_r <= S_COPY;
          end
        end
        S_COPY: begin
          if (ph_r == PH_RD0) begin
            ph_r <= PH_RD1;
          end else begin
            ph_r <= PH_RD0;
            if (cnt_r + CW'(1) < n_w) begin
              cnt_r <= cnt_r + CW'(1);
            end else begin
              cnt_r <= '0;
              blk_r <= '0;
              j_r <= '0;
              w_r <= npc_pkg::ONE;
              sel_b_r <= 1'b0;
              lg_r <= lgn_r;
              state_r <= (lgn_r == '0) ? S_PMUL : S_FWD;
            end
          end
        end
        S_FWD, S_INV: begin
          if (ph_r == PH_RD1) u_r <= bf_rdata;
          if (ph_r == PH_CAPV) v_r <= bf_rdata;
          if (ph_r == PH_OPND) begin
            sum_r <= npc_pkg::add_mod(u_r, v_r);
            opa_r <= (state_r == S_FWD) ? npc_pkg::sub_mod(u_r, v_r) : v_r;
          end
          if (ph_r == PH_PROD) diff_r <= npc_pkg::sub_mod(u_r, mul_y);
          if (ph_r == PH_LAST) begin
            ph_r <= PH_RD0;
            if (CW'(j_r) + CW'(1) < half_w) begin
              j_r <= j_r + WAW'(1);
              w_r <= mul_y;
            end else begin
              j_r <= '0;
              w_r <= npc_pkg::ONE;
              if (blk_r + len_w < n_w) begin
                blk_r <= blk_r + len_w;
              end else begin
                blk_r <= '0;
                if (state_r == S_FWD) begin
                  if (lg_r != LGW'(1)) begin
                    lg_r <= lg_r - LGW'(1);
                  end else if (!sel_b_r) begin
                    sel_b_r <= 1'b1;
                    lg_r <= lgn_r;
                  end else begin
                    sel_b_r <= 1'b0;
                    cnt_r <= '0;
                    state_r <= S_PMUL;
                  end
                end else begin
                  if (lg_r != lgn_r) begin
                    lg_r <= lg_r + LGW'(1);
                  end else begin
                    cnt_r <= '0;
                    state_r <= S_SCALE;
                  end
                end
              end
            end
          end else begin
            ph_r <= ph_r + PHW'(1);
          end
        end
        S_PMUL, S_SCALE: begin
          if (ph_r == PH_PWR) begin
            ph_r <= PH_RD0;
            if (cnt_r + CW'(1) < n_w) begin
              cnt_r <= cnt_r + CW'(1);
            end else if (state_r == S_PMUL) begin
              cnt_r <= '0;
              lg_r <= LGW'(1);
              state_r <= (lgn_r == '0) ? S_SCALE : S_INV;
            end else begin
              out_coef_r <= '0;
              out_status_r <= npc_pkg::ST_OK;
              res_valid_r <= 1'b1;
              res_len_r <= need_r;
              state_r <= S_IDLE;
            end
          end else begin
            ph_r <= ph_r + PHW'(1);
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while a command is in progress");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != npc_pkg::ST_OK)) |-> (out_coefficient == '0))
    else $error("nonzero coefficient with an error status");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (res_len_r != '0))
    else $error("valid result with zero length");

  a_cap_err: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (mode_w == npc_pkg::MODE_COMPUTE) && len_bad) |=>
      (out_valid && (out_status == npc_pkg::ST_CAP) && !res_valid_r))
    else $error("bad lengths did not report a capacity error");
`endif

endmodule

/* src/npc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the operand stores and the transform work buffers; no dependencies.
module npc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/npc_modmul.sv */
// Pipelined modular multiplier with Barrett reduction.
// Depends on npc_pkg for the modulus and the Barrett constant.
module npc_modmul (
  input  logic                      clk,
  input  logic [npc_pkg::VAL_W-1:0] a,
  input  logic [npc_pkg::VAL_W-1:0] b,
  output logic [npc_pkg::VAL_W-1:0] y
);

  localparam int VW = npc_pkg::VAL_W;

  logic [2*VW-1:0] prod_r;
  logic [VW:0]     q_r;
  logic [31:0]     lo1_r;
  logic [31:0]     lo2_r;
  logic [31:0]     qp_r;
  logic [31:0]     r_r;
  logic [VW-1:0]   y_r;
  logic [2*VW+1:0] q_full;
  logic [31:0]     r_fix;

  assign q_full = {31'd0, prod_r[2*VW-1:VW-1]} * {31'd0, npc_pkg::MU};

  // The quotient estimate is low by at most two, so r is below three times the modulus.
  always_comb begin
    r_fix = r_r;
    if (r_r >= {1'b0, npc_pkg::P, 1'b0}) r_fix = r_r - {1'b0, npc_pkg::P, 1'b0};
    else if (r_r >= {2'b0, npc_pkg::P}) r_fix = r_r - {2'b0, npc_pkg::P};
  end

  always_ff @(posedge clk) begin
    prod_r <= {30'd0, a} * {30'd0, b};
    q_r    <= q_full[2*VW+1:VW+1];
    lo1_r  <= prod_r[31:0];
    qp_r   <= 32'({1'b0, q_r} * {2'b0, npc_pkg::P});
    lo2_r  <= lo1_r;
    r_r    <= lo2_r - qp_r;
    y_r    <= r_fix[VW-1:0];
  end

  assign y = y_r;

endmodule
